// ===== sv/lfuc_pkg.sv =====
// Package: shared constants, types and state codes of the LFU block cache tag store.
`timescale 1ns / 1ps
`default_nettype none

package lfuc_pkg;

  // Number of tag slots built into the store.
  localparam int CACHE_SLOTS = 16;
  // Bits that index one slot, and bits that hold a slot count up to CACHE_SLOTS.
  localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);

  // Field widths.
  localparam int FILE_W   = 16;
  localparam int OFF_W    = 40;
  localparam int BCNT_W   = 18;
  localparam int BLK_W    = 28;
  localparam int USES_W   = 32;
  localparam int OSLOT_W  = 4;
  localparam int END_W    = OFF_W + 1;
  localparam int REM_W    = 6;
  localparam int CREG_W   = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [BCNT_W-1:0] MAX_COUNT = 18'd131072;
  localparam logic [CREG_W-1:0] SHIFT_MIN = 5'd12;
  localparam logic [CREG_W-1:0] SHIFT_MAX = 5'd20;
  localparam logic [CREG_W-1:0] BLOCKS_RST = 5'd16;

  // Register indexes as decoded from paddr[2].
  localparam logic REG_CACHE_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_SIZE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RANGE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc_end;
    logic calc_range;
    logic scan_step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic last_block;
    logic out_free;
  } dp_status_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic              blocks_wr;
    logic [CNT_W-1:0]  blocks_new;
    logic [CNT_W-1:0]  slots_on;
    logic [CREG_W-1:0] shift;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/lfuc_req_if.sv =====
// Interface: request channel carrying one read request word.
`timescale 1ns / 1ps
`default_nettype none

interface lfuc_req_if import lfuc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FILE_W-1:0] file_id;
  logic [OFF_W-1:0]  byte_offset;
  logic [BCNT_W-1:0] byte_count;

  modport source (output valid, output file_id, output byte_offset, output byte_count,
                  input ready);
  modport sink (input valid, input file_id, input byte_offset, input byte_count,
                output ready);
endinterface

`default_nettype wire

// ===== sv/lfuc_rsp_if.sv =====
// Interface: result channel carrying one per-block lookup word.
`timescale 1ns / 1ps
`default_nettype none

interface lfuc_rsp_if import lfuc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLK_W-1:0]   block_index;
  logic               hit;
  logic [OSLOT_W-1:0] slot;
  logic               evicted;
  logic [FILE_W-1:0]  evicted_file;
  logic [BLK_W-1:0]   evicted_block;
  logic               last_of_request;

  modport source (output valid, output block_index, output hit, output slot,
                  output evicted, output evicted_file, output evicted_block,
                  output last_of_request, input ready);
  modport sink (input valid, input block_index, input hit, input slot,
                input evicted, input evicted_file, input evicted_block,
                input last_of_request, output ready);
endinterface

`default_nettype wire

// ===== sv/lfuc_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module lfuc_regs import lfuc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [CREG_W-1:0] cache_blocks;
  logic [CREG_W-1:0] block_size_log2;
  logic              wr_en;
  logic [CREG_W-1:0] wdata;

  // Map a cache_blocks value onto the number of slots in use.
  function automatic logic [CNT_W-1:0] clamp_slots(input logic [CREG_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (32'(v) > 32'(CACHE_SLOTS)) begin
      n = CNT_W'(CACHE_SLOTS);
    end else begin
      n = CNT_W'(v);
    end
    return n;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[CREG_W-1:0];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_blocks    <= BLOCKS_RST;
      block_size_log2 <= SHIFT_MIN;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_CACHE_BLOCKS: cache_blocks    <= wdata;
        REG_BLOCK_SIZE:   block_size_log2 <= wdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (paddr[2])
      REG_CACHE_BLOCKS: prdata = PDATA_W'(cache_blocks);
      REG_BLOCK_SIZE:   prdata = PDATA_W'(block_size_log2);
      default:          prdata = '0;
    endcase
  end

  // Effective values handed to the datapath.
  always_comb begin
    cfg.blocks_wr  = wr_en && (paddr[2] == REG_CACHE_BLOCKS);
    cfg.blocks_new = clamp_slots(wdata);
    cfg.slots_on   = clamp_slots(cache_blocks);
    if (block_size_log2 < SHIFT_MIN) begin
      cfg.shift = SHIFT_MIN;
    end else if (block_size_log2 > SHIFT_MAX) begin
      cfg.shift = SHIFT_MAX;
    end else begin
      cfg.shift = block_size_log2;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfuc_ctrl.sv =====
// Controller: sequences request setup, slot scans and result commits.
`timescale 1ns / 1ps
`default_nettype none

module lfuc_ctrl import lfuc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        if (req_valid && !sts.cnt_zero) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.calc_end = 1'b1;
        state_next   = ST_RANGE;
      end
      ST_RANGE: begin
        cmd.calc_range = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = sts.last_block ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lfuc_dp.sv =====
// Datapath: tag store, block range arithmetic, slot scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module lfuc_dp import lfuc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             sts,
  input  wire logic [FILE_W-1:0] file_id,
  input  wire logic [OFF_W-1:0]  byte_offset,
  input  wire logic [BCNT_W-1:0] byte_count,
  lfuc_rsp_if.source             rsp
);

  // Tag store.
  logic              slot_valid [CACHE_SLOTS];
  logic              slot_fresh [CACHE_SLOTS];
  logic [FILE_W-1:0] slot_file  [CACHE_SLOTS];
  logic [BLK_W-1:0]  slot_block [CACHE_SLOTS];
  logic [USES_W-1:0] slot_uses  [CACHE_SLOTS];

  // Request registers.
  logic [FILE_W-1:0] cur_file;
  logic [OFF_W-1:0]  cur_off;
  logic [BCNT_W-1:0] cur_cnt;
  logic [END_W-1:0]  end_byte;
  logic [BLK_W-1:0]  blk_cur;
  logic [REM_W-1:0]  remain;

  // Scan registers.
  logic [SLOT_W-1:0] scan_idx;
  logic              found_v;
  logic [SLOT_W-1:0] found_idx;
  logic [USES_W-1:0] found_uses;
  logic              free_v;
  logic [SLOT_W-1:0] free_idx;
  logic              vic_v;
  logic [SLOT_W-1:0] vic_idx;
  logic [USES_W-1:0] vic_uses;
  logic [FILE_W-1:0] vic_file;
  logic [BLK_W-1:0]  vic_block;

  // Result register.
  logic out_valid;

  // Combinational helpers.
  logic [OFF_W-1:0]     first_off;
  logic [END_W-1:0]     end_shift;
  logic [BLK_W:0]       blk_diff;
  logic                 rd_valid;
  logic                 rd_fresh;
  logic [FILE_W-1:0]    rd_file;
  logic [BLK_W-1:0]     rd_block;
  logic [USES_W-1:0]    rd_uses;
  logic                 rd_match;
  logic                 idx_last;
  logic                 install;
  logic                 do_evict;
  logic [SLOT_W-1:0]    tgt;
  logic [SLOT_W+3:0]    tgt_ext;
  logic                 last_blk;

  // Block range of the request.
  assign first_off = cur_off >> cfg.shift;
  assign end_shift = end_byte >> cfg.shift;
  assign blk_diff  = end_shift[BLK_W:0] - {1'b0, first_off[BLK_W-1:0]};
  assign last_blk  = (remain == '0);

  // Entry under the scan pointer.
  assign rd_valid = slot_valid[scan_idx];
  assign rd_fresh = slot_fresh[scan_idx];
  assign rd_file  = slot_file[scan_idx];
  assign rd_block = slot_block[scan_idx];
  assign rd_uses  = slot_uses[scan_idx];
  assign rd_match = rd_valid && (rd_file == cur_file) && (rd_block == blk_cur);
  assign idx_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == cfg.slots_on);

  // Outcome of the finished scan.
  always_comb begin
    install  = !found_v && (free_v || vic_v);
    do_evict = !found_v && !free_v && vic_v;
    if (found_v) begin
      tgt = found_idx;
    end else if (free_v) begin
      tgt = free_idx;
    end else if (vic_v) begin
      tgt = vic_idx;
    end else begin
      tgt = '0;
    end
    tgt_ext = {4'b0000, tgt};
  end

  always_comb begin
    sts.cnt_zero   = (byte_count == '0);
    sts.scan_last  = idx_last;
    sts.last_block = last_blk;
    sts.out_free   = !out_valid || rsp.ready;
  end

  // Request capture and block stepping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_file <= file_id;
      cur_off  <= byte_offset;
      cur_cnt  <= (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
    end
    if (cmd.calc_end) begin
      end_byte <= {1'b0, cur_off} + END_W'(cur_cnt) - END_W'(1);
    end
    if (cmd.calc_range) begin
      blk_cur <= first_off[BLK_W-1:0];
      remain  <= blk_diff[REM_W-1:0];
    end else if (cmd.commit && !last_blk) begin
      blk_cur <= blk_cur + BLK_W'(1);
      remain  <= remain - REM_W'(1);
    end
  end

  // Slot scan: first match, first free slot and least-used old slot in one pass.
  always_ff @(posedge clk) begin
    if (rst || cmd.calc_range || cmd.commit) begin
      scan_idx <= '0;
      found_v  <= 1'b0;
      free_v   <= 1'b0;
      vic_v    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= idx_last ? '0 : scan_idx + SLOT_W'(1);
      if (rd_match && !found_v) begin
        found_v    <= 1'b1;
        found_idx  <= scan_idx;
        found_uses <= rd_uses;
      end
      if (!rd_valid && !free_v) begin
        free_v   <= 1'b1;
        free_idx <= scan_idx;
      end
      if (rd_valid && !rd_fresh && (!vic_v || (rd_uses < vic_uses))) begin
        vic_v     <= 1'b1;
        vic_idx   <= scan_idx;
        vic_uses  <= rd_uses;
        vic_file  <= rd_file;
        vic_block <= rd_block;
      end
    end
  end

  // Valid and fresh bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_fresh[i] <= 1'b0;
      end
    end else if (cfg.blocks_wr) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (CNT_W'(i) >= cfg.blocks_new) begin
          slot_valid[i] <= 1'b0;
          slot_fresh[i] <= 1'b0;
        end
      end
    end else if (cmd.commit) begin
      if (install) begin
        slot_valid[tgt] <= 1'b1;
      end
      if (last_blk) begin
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          slot_fresh[i] <= 1'b0;
        end
      end else if (install) begin
        slot_fresh[tgt] <= 1'b1;
      end
    end
  end

  // Tag and use-count writes.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (found_v) begin
        if (found_uses != '1) begin
          slot_uses[found_idx] <= found_uses + USES_W'(1);
        end
      end else if (install) begin
        slot_file[tgt]  <= cur_file;
        slot_block[tgt] <= blk_cur;
        slot_uses[tgt]  <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.block_index     <= blk_cur;
      rsp.hit             <= found_v;
      rsp.slot            <= tgt_ext[OSLOT_W-1:0];
      rsp.evicted         <= do_evict;
      rsp.evicted_file    <= do_evict ? vic_file : '0;
      rsp.evicted_block   <= do_evict ? vic_block : '0;
      rsp.last_of_request <= last_blk;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== sv/lfu_block_cache_tags.sv =====
// Top level: LFU block cache tag store with request, result and register ports.
//
//   Port      Dir   Handshake       Word
//   req       in    valid/ready     file_id, byte_offset, byte_count
//   rsp       out   valid/ready     block_index, hit, slot, evicted, evicted_file,
//                                   evicted_block, last_of_request
//   APB       in    psel/penable    cache_blocks at 0x0, block_size_log2 at 0x4
//
// A request is taken in the idle state. Then come the setup states ST_SETUP, which
// computes the end byte, and ST_RANGE, which computes the block range. Each block then
// takes a scan through the tag store over the N slots in use and a commit, which waits
// while the output register holds a stalled word. After the last commit of a request
// the controller is back in idle in the following cycle, ready for the next request.
// A request with a zero byte count is taken in the idle state and gives no word.
// Reset clears the valid and fresh bits at once; there is no clearing pass.
// A stalled result word holds in the output register; the next block's scan
// runs meanwhile, and only its commit waits for the register to empty.
`timescale 1ns / 1ps
`default_nettype none

module lfu_block_cache_tags import lfuc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  lfuc_req_if.sink                req,
  lfuc_rsp_if.source              rsp
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       req_ready;

  assign req.ready = req_ready;

  // Configuration registers.
  lfuc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  lfuc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tag store and arithmetic.
  lfuc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .file_id     (req.file_id),
    .byte_offset (req.byte_offset),
    .byte_count  (req.byte_count),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
